>>> hdl/krrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krrt_pkg: shared types and constants of the rollover report table
// Event, status and report kind codes, slot geometry and sequencer states.
// ----------------------------------------------------------------------------
package krrt_pkg;

    localparam int KEY_SLOTS  = 6;                          // slots in the table
    localparam int SHOWN_KEYS = 6;                          // slots shown in a result
    localparam int IDX_W      = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int KEY_W      = 8;
    localparam int CODE_W     = 2;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [CODE_W-1:0] {
        FUNC_MODIFIER = 2'd0,
        FUNC_PRESS    = 2'd1,
        FUNC_RELEASE  = 2'd2,
        FUNC_DONE     = 2'd3
    } t_func;

    typedef enum logic [CODE_W-1:0] {
        ST_SENT = 2'd0,
        ST_BUSY = 2'd1,
        ST_HELD = 2'd2,
        ST_DONE = 2'd3
    } t_status;

    typedef enum logic [CODE_W-1:0] {
        KIND_IDLE     = 2'd0,
        KIND_MODIFIER = 2'd1,
        KIND_PRESS    = 2'd2,
        KIND_RELEASE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_APPLY  = 2'd2,
        S_RESULT = 2'd3
    } t_state;

endpackage : krrt_pkg
`default_nettype wire

>>> hdl/krrt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krrt_if: event and result channels of the rollover report table
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface krrt_in_if import krrt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] func;
    logic [KEY_W-1:0]  value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface : krrt_in_if

interface krrt_out_if import krrt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] status;
    logic              send_report;
    logic [KEY_W-1:0]  modifier_out;
    logic [KEY_W-1:0]  key_a;
    logic [KEY_W-1:0]  key_b;
    logic [KEY_W-1:0]  key_c;
    logic [KEY_W-1:0]  key_d;
    logic [KEY_W-1:0]  key_e;
    logic [KEY_W-1:0]  key_f;
    logic              overflow_flag;
    logic [CODE_W-1:0] completed_kind;

    modport source (output valid, output status, output send_report, output modifier_out,
                    output key_a, output key_b, output key_c, output key_d, output key_e,
                    output key_f, output overflow_flag, output completed_kind,
                    input ready);
    modport sink   (input valid, input status, input send_report, input modifier_out,
                    input key_a, input key_b, input key_c, input key_d, input key_e,
                    input key_f, input overflow_flag, input completed_kind,
                    output ready);
endinterface : krrt_out_if
`default_nettype wire

>>> hdl/keyboard_rollover_report_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyboard_rollover_report_table_top: boot keyboard six-key report table
// Holds a modifier byte and an ascending key table; one result per event.
// ----------------------------------------------------------------------------
// Each event beat on i_in yields exactly one result beat on o_out. The block
// handles one event at a time and drops i_in.ready until the result beat has
// been taken. A modifier change, a write complete, or any event refused as
// busy is accepted and then goes straight to the result. A key press or
// release first walks the key table: one shared comparator reads one slot
// per cycle to find a held key and the sorted insert point, the apply state
// then performs the insert or remove shift on all slots, and then the
// result is presented. The report fields on o_out show the table as it
// stands after the event and hold steady while the result waits.
// ----------------------------------------------------------------------------
module keyboard_rollover_report_table_top import krrt_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    krrt_in_if.sink     i_in,
    krrt_out_if.source  o_out
);

    localparam t_idx LAST_IDX = t_idx'(KEY_SLOTS - 1);

    // sequencer
    t_state  r_state, n_state;

    // report table
    t_key    r_slots [KEY_SLOTS];
    t_key    n_slots [KEY_SLOTS];
    t_key    r_mod,   n_mod;
    t_kind   r_pend,  n_pend;
    logic    r_ovf,   n_ovf;

    // captured event and scan results
    t_func   r_func,  n_func;
    t_key    r_val,   n_val;
    t_idx    r_idx,   n_idx;
    logic    r_held,  n_held;
    t_idx    r_hidx,  n_hidx;
    t_idx    r_pos,   n_pos;
    logic    r_pos_ok, n_pos_ok;

    // result beat
    t_status r_status, n_status;
    logic    r_send,   n_send;
    t_kind   r_kind,   n_kind;

    logic    in_fire;
    logic    out_fire;
    t_key    scan_key;
    logic    scan_eq;
    logic    scan_stop;
    t_key    shown [SHOWN_KEYS];

    assign in_fire  = i_in.valid  & i_in.ready;
    assign out_fire = o_out.valid & o_out.ready;

    // Shared compare unit: one slot per cycle against the captured key.
    assign scan_key  = r_slots[r_idx];
    assign scan_eq   = (scan_key != '0) && (scan_key == r_val);
    assign scan_stop = (scan_key == '0) || (scan_key > r_val);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    // Write complete, busy and modifier change need no scan.
                    if ((t_func'(i_in.func) == FUNC_DONE) || (r_pend != KIND_IDLE) ||
                        (t_func'(i_in.func) == FUNC_MODIFIER)) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (out_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb begin
        i_in.ready  = (r_state == S_IDLE);
        o_out.valid = (r_state == S_RESULT);
    end

    // Datapath next values
    always_comb begin
        n_slots  = r_slots;
        n_mod    = r_mod;
        n_pend   = r_pend;
        n_ovf    = r_ovf;
        n_func   = r_func;
        n_val    = r_val;
        n_idx    = r_idx;
        n_held   = r_held;
        n_hidx   = r_hidx;
        n_pos    = r_pos;
        n_pos_ok = r_pos_ok;
        n_status = r_status;
        n_send   = r_send;
        n_kind   = r_kind;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_func   = t_func'(i_in.func);
                    n_val    = i_in.value;
                    n_idx    = '0;
                    n_held   = 1'b0;
                    n_hidx   = '0;
                    n_pos    = LAST_IDX;
                    n_pos_ok = 1'b0;
                    n_send   = 1'b0;
                    n_kind   = KIND_IDLE;
                    if (t_func'(i_in.func) == FUNC_DONE) begin
                        // Close the pending report and name its kind.
                        n_status = ST_DONE;
                        n_kind   = r_pend;
                        n_pend   = KIND_IDLE;
                    end else if (r_pend != KIND_IDLE) begin
                        n_status = ST_BUSY;
                    end else if (t_func'(i_in.func) == FUNC_MODIFIER) begin
                        n_mod    = i_in.value;
                        n_pend   = KIND_MODIFIER;
                        n_status = ST_SENT;
                        n_send   = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                // Record the first matching slot and the first slot that
                // would take the new key; the last slot is the fallback.
                if (scan_eq && !r_held) begin
                    n_held = 1'b1;
                    n_hidx = r_idx;
                end
                if (scan_stop && !r_pos_ok && (r_idx != LAST_IDX)) begin
                    n_pos    = r_idx;
                    n_pos_ok = 1'b1;
                end
                if (r_idx != LAST_IDX) begin
                    n_idx = r_idx + t_idx'(1);
                end
            end
            S_APPLY: begin
                if (r_func == FUNC_PRESS) begin
                    if ((r_val != '0) && r_held) begin
                        n_status = ST_HELD;
                        n_send   = 1'b0;
                    end else begin
                        if (r_slots[KEY_SLOTS-1] != '0) begin
                            n_ovf = 1'b1;
                        end else if (r_val != '0) begin
                            // Sorted insert: shift the tail right by one.
                            for (int j = 1; j < KEY_SLOTS; j++) begin
                                if (t_idx'(j) > r_pos) begin
                                    n_slots[j] = r_slots[j-1];
                                end
                            end
                            n_slots[r_pos] = r_val;
                        end
                        n_pend   = KIND_PRESS;
                        n_status = ST_SENT;
                        n_send   = 1'b1;
                    end
                end else begin
                    n_ovf = 1'b0;
                    if ((r_val != '0) && r_held) begin
                        // Remove: shift the tail left and clear the last slot.
                        for (int j = 0; j < KEY_SLOTS - 1; j++) begin
                            if (t_idx'(j) >= r_hidx) begin
                                n_slots[j] = r_slots[j+1];
                            end
                        end
                        n_slots[KEY_SLOTS-1] = '0;
                    end
                    n_pend   = KIND_RELEASE;
                    n_status = ST_SENT;
                    n_send   = 1'b1;
                end
            end
            S_RESULT: begin
                // Hold the result until it is taken.
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= KIND_IDLE;
            r_mod   <= '0;
            r_ovf   <= 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++) begin
                r_slots[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_mod   <= n_mod;
            r_ovf   <= n_ovf;
            r_slots <= n_slots;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_held   <= n_held;
        r_hidx   <= n_hidx;
        r_pos    <= n_pos;
        r_pos_ok <= n_pos_ok;
        r_status <= n_status;
        r_send   <= n_send;
        r_kind   <= n_kind;
    end

    // Map table slots onto the six report positions; absent slots read zero.
    for (genvar g = 0; g < SHOWN_KEYS; g++) begin : g_shown
        if (g < KEY_SLOTS) begin : g_used
            assign shown[g] = r_slots[g];
        end else begin : g_empty
            assign shown[g] = '0;
        end
    end

    always_comb begin
        o_out.status         = r_status;
        o_out.send_report    = r_send;
        o_out.modifier_out   = r_mod;
        o_out.key_a          = shown[0];
        o_out.key_b          = shown[1];
        o_out.key_c          = shown[2];
        o_out.key_d          = shown[3];
        o_out.key_e          = shown[4];
        o_out.key_f          = shown[5];
        o_out.overflow_flag  = r_ovf;
        o_out.completed_kind = r_kind;
    end

endmodule : keyboard_rollover_report_table_top
`default_nettype wire

>>> hdl/krrt_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krrt_chk: port checker for the rollover report table
// Watches the channels of the top level over time.
// ----------------------------------------------------------------------------
module krrt_chk import krrt_pkg::*; (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_in_ready,
    input wire              i_out_valid,
    input wire              i_out_ready,
    input wire [CODE_W-1:0] i_status,
    input wire              i_send_report,
    input wire [KEY_W-1:0]  i_key_a,
    input wire [KEY_W-1:0]  i_key_b,
    input wire [KEY_W-1:0]  i_key_c,
    input wire [CODE_W-1:0] i_completed_kind
);

    // One event at a time: never ready for an event while a result waits.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("event accepted while a result is pending");

    // A stalled result beat stays valid with its status unchanged.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status)))
        else $error("result dropped or changed while stalled");

    // Only a sent report carries the send flag.
    a_send_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_send_report) |-> (i_status == ST_SENT))
        else $error("report issued with a non-sent status");

    // A finished kind shows only on write complete.
    a_kind_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_completed_kind != KIND_IDLE)) |-> (i_status == ST_DONE))
        else $error("completed kind outside write complete");

    // The first three keys stay strictly ascending with empty slots at the end.
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (((i_key_b == '0) || ((i_key_a != '0) && (i_key_a < i_key_b))) &&
                         ((i_key_c == '0) || ((i_key_b != '0) && (i_key_b < i_key_c)))))
        else $error("key table out of order");

endmodule : krrt_chk

bind keyboard_rollover_report_table_top krrt_chk u_krrt_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_status         (o_out.status),
    .i_send_report    (o_out.send_report),
    .i_key_a          (o_out.key_a),
    .i_key_b          (o_out.key_b),
    .i_key_c          (o_out.key_c),
    .i_completed_kind (o_out.completed_kind)
);
`default_nettype wire
